// File: design/unit_circle_point_sampler_core_defines.svh
// ----------------------------------------------------------------------------
// unit circle point sampler assertion macros
// shared concurrent check forms used by the sampler rtl
// ----------------------------------------------------------------------------
`ifndef UNIT_CIRCLE_POINT_SAMPLER_CORE_DEFINES_SVH
`define UNIT_CIRCLE_POINT_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UCPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define UCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ucps_pkg.sv
// ----------------------------------------------------------------------------
// ucps_pkg
// types and constants shared by the unit circle point sampler
// ----------------------------------------------------------------------------
`default_nettype none

package ucps_pkg;

	localparam int XY_W = 34;

	localparam logic [14:0] LCG_MULT    = 15'd16807;
	localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
	localparam logic [31:0] GOLDEN_STEP = 32'd1640531527;
	localparam logic [30:0] SEED_RESET  = 31'd123456789;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i) in 2^-32 turns
	localparam logic [31:0] ATAN_TURNS [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// command codes
	localparam logic CMD_RANDOM  = 1'b0;
	localparam logic CMD_ERGODIC = 1'b1;

	// register word index
	localparam logic REG_START_SEED  = 1'b0;
	localparam logic REG_START_PHASE = 1'b1;

	// one point travelling down the rotation chain
	typedef struct packed {
		logic                   vld;
		logic                   flip;
		logic                   last;
		logic [31:0]            phase;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [XY_W-1:0] z;
	} cordic_bus_t;

	// register writes toward the point generator
	typedef struct packed {
		logic        seed_we;
		logic        phase_we;
		logic [30:0] seed;
		logic [31:0] phase;
	} cfg_wr_t;

endpackage

`default_nettype wire

// File: design/ucps_cordic_cell.sv
// ----------------------------------------------------------------------------
// ucps_cordic_cell
// one rotation step of the cordic chain, advancing on the shared enable
// ----------------------------------------------------------------------------
`default_nettype none

module ucps_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,
	input  wire ucps_pkg::cordic_bus_t din,
	output ucps_pkg::cordic_bus_t      dout
);

	localparam logic signed [ucps_pkg::XY_W-1:0] ANG =
		{2'b00, ucps_pkg::ATAN_TURNS[STAGE]};

	logic signed [ucps_pkg::XY_W-1:0] dx, dy;
	logic                             vld_q;
	ucps_pkg::cordic_bus_t            pay_q;

	assign dx = din.y >>> STAGE;
	assign dy = din.x >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && din.vld) begin
			pay_q.vld   <= din.vld;
			pay_q.flip  <= din.flip;
			pay_q.last  <= din.last;
			pay_q.phase <= din.phase;
			if (!din.z[ucps_pkg::XY_W-1]) begin
				pay_q.x <= din.x - dx;
				pay_q.y <= din.y + dy;
				pay_q.z <= din.z - ANG;
			end else begin
				pay_q.x <= din.x + dx;
				pay_q.y <= din.y - dy;
				pay_q.z <= din.z + ANG;
			end
		end
	end

	always_comb begin
		dout     = pay_q;
		dout.vld = vld_q;
	end

endmodule

`default_nettype wire

// File: design/ucps_point_gen.sv
// ----------------------------------------------------------------------------
// ucps_point_gen
// request sequencer, minimal standard generator and golden angle phase
// ----------------------------------------------------------------------------
`default_nettype none

`include "unit_circle_point_sampler_core_defines.svh"

module ucps_point_gen #(
	parameter int MAX_POINTS = 64,
	parameter int PHASE_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    adv,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  wire                    req_mode,
	input  wire  [6:0]             req_count,
	input  wire ucps_pkg::cfg_wr_t cfg_wr,
	output ucps_pkg::cordic_bus_t  issue
);

	localparam logic [6:0]  MAX_CNT    = 7'(MAX_POINTS);
	localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_FOLD, S_RUN} state_t;

	state_t                state_q;
	logic [6:0]            points_left_q;
	logic                  mode_q;
	logic [30:0]           seed_q;
	logic [31:0]           phase_q;
	logic [45:0]           prod_q;
	ucps_pkg::cordic_bus_t issue_q;

	logic [6:0]  count_sat;
	logic [31:0] fold_sum;
	logic [30:0] seed_next;
	logic [31:0] raw_phase, kept_phase, turn_test, folded_phase;
	logic        fold_flip;
	logic        fire;

	function automatic logic [30:0] clean_seed(input logic [30:0] s);
		if (s == 31'd0 || s == ucps_pkg::LCG_MOD) begin
			return 31'd1;
		end
		return s;
	endfunction

	assign count_sat = (req_count > MAX_CNT) ? MAX_CNT : req_count;
	assign req_ready = (state_q == S_IDLE);

	// x mod (2^31 - 1) folds the high part back onto the low part
	assign fold_sum  = {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
	assign seed_next = (fold_sum >= {1'b0, ucps_pkg::LCG_MOD}) ?
		31'(fold_sum - {1'b0, ucps_pkg::LCG_MOD}) : fold_sum[30:0];

	assign raw_phase    = (mode_q == ucps_pkg::CMD_RANDOM) ? {seed_next, 1'b0} : phase_q;
	assign kept_phase   = raw_phase & PHASE_MASK;
	// fold into [-1/4, 1/4) turn
	assign turn_test    = kept_phase + 32'h4000_0000;
	assign fold_flip    = turn_test[31];
	assign folded_phase = fold_flip ? kept_phase + 32'h8000_0000 : kept_phase;

	assign fire = adv && ((state_q == S_FOLD) || (state_q == S_RUN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			points_left_q <= 7'd0;
			mode_q        <= ucps_pkg::CMD_RANDOM;
			seed_q        <= ucps_pkg::SEED_RESET;
			phase_q       <= 32'd0;
			prod_q        <= 46'd0;
			issue_q       <= '0;
		end else begin
			if (adv) begin
				issue_q.vld <= fire;
			end
			if (fire) begin
				issue_q.flip  <= fold_flip;
				issue_q.last  <= (points_left_q == 7'd1);
				issue_q.phase <= kept_phase;
				issue_q.x     <= ucps_pkg::CORDIC_GAIN;
				issue_q.y     <= '0;
				issue_q.z     <= {{2{folded_phase[31]}}, folded_phase};
				points_left_q <= points_left_q - 7'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_wr.seed_we) begin
						seed_q <= clean_seed(cfg_wr.seed);
					end
					if (cfg_wr.phase_we) begin
						phase_q <= cfg_wr.phase;
					end
					if (req_valid && count_sat != 7'd0) begin
						mode_q        <= req_mode;
						points_left_q <= count_sat;
						state_q       <= (req_mode == ucps_pkg::CMD_RANDOM) ? S_MUL : S_RUN;
					end
				end
				S_MUL: begin
					prod_q  <= 46'(seed_q) * 46'(ucps_pkg::LCG_MULT);
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (adv) begin
						seed_q  <= seed_next;
						state_q <= (points_left_q == 7'd1) ? S_IDLE : S_MUL;
					end
				end
				S_RUN: begin
					if (adv) begin
						phase_q <= phase_q + ucps_pkg::GOLDEN_STEP;
						if (points_left_q == 7'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign issue = issue_q;

	`UCPS_ASSERT_NOW(a_seed_legal, clk, arst_n, 1'b1,
		seed_q != 31'd0 && seed_q != ucps_pkg::LCG_MOD, "generator seed left its legal range")
	`UCPS_ASSERT_NOW(a_fire_owed, clk, arst_n, fire,
		points_left_q != 7'd0, "point issued with no points owed")
	`UCPS_ASSERT_NOW(a_idle_clear, clk, arst_n, req_ready,
		points_left_q == 7'd0, "idle while points still owed")
	`UCPS_ASSERT_NEXT(a_last_idle, clk, arst_n, fire && points_left_q == 7'd1,
		req_ready, "sequencer did not return to idle after the last point")

endmodule

`default_nettype wire

// File: design/unit_circle_point_sampler_core.sv
// ----------------------------------------------------------------------------
// unit_circle_point_sampler_core
// points on the unit circle from a random or golden-angle phase via cordic
// ----------------------------------------------------------------------------
// A request transaction on the slave stream carries a mode (tuser) and a point
// count (tdata); the block answers with that many (cos, sin, phase) points on
// the master stream, tlast on the final one. A count of zero produces nothing,
// a count above MAX_POINTS is clipped. In random mode the sequencer issues
// each point through a 31x15 generator multiply state and a modulo fold
// state, in ergodic mode through a single run state; the next request is
// taken as soon as the sequencer is idle, even while earlier points still
// drain. Each point then passes the chain of CORDIC_STAGES rotation cells and
// one output register. Back-pressure on the master stream freezes the whole
// chain. Writing start_seed (address 0) reloads the generator seed, a value of
// 0 or 2^31-1 becomes 1; writing start_phase (address 4) reloads the ergodic
// phase. Write registers only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unit_circle_point_sampler_core_defines.svh"

module unit_circle_point_sampler_core #(
	parameter int MAX_POINTS    = 64,
	parameter int PHASE_BITS    = 32,
	parameter int CORDIC_STAGES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// request stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [6:0] point_count, [7] zero
	input  wire         s_axis_tuser,   // [0] command
	// point stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [15:0] coord_x, [31:16] coord_y, [63:32] phase_used
	output logic        m_axis_tlast,   // last_point
	// register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int XW = ucps_pkg::XY_W;

	logic [30:0]           start_seed_q;
	logic [31:0]           start_phase_q;
	logic                  wr_en;
	ucps_pkg::cfg_wr_t     cfg_wr;
	ucps_pkg::cordic_bus_t chain [CORDIC_STAGES+1];
	ucps_pkg::cordic_bus_t tail;
	logic                  adv;

	logic                 out_vld_q;
	logic                 out_last_q;
	logic signed [15:0]   out_x_q, out_y_q;
	logic [31:0]          out_phase_q;
	logic signed [XW-1:0] x_fin, y_fin;

	// round to Q2.14 toward minus infinity after adding half, then clamp to +-1.0
	function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + XW'(32768)) >>> 16;
		if (r > XW'(16384)) begin
			return 16'sd16384;
		end
		if (r < -XW'(16384)) begin
			return -16'sd16384;
		end
		return r[15:0];
	endfunction

	// register port: word index in paddr[2], writes land on the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seed_q  <= ucps_pkg::SEED_RESET;
			start_phase_q <= 32'd0;
		end else if (wr_en) begin
			case (paddr[2])
				ucps_pkg::REG_START_SEED:  start_seed_q  <= pwdata[30:0];
				ucps_pkg::REG_START_PHASE: start_phase_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ucps_pkg::REG_START_SEED:  prdata = {1'b0, start_seed_q};
			ucps_pkg::REG_START_PHASE: prdata = start_phase_q;
			default:                   prdata = 32'd0;
		endcase
	end

	assign cfg_wr.seed_we  = wr_en && (paddr[2] == ucps_pkg::REG_START_SEED);
	assign cfg_wr.phase_we = wr_en && (paddr[2] == ucps_pkg::REG_START_PHASE);
	assign cfg_wr.seed     = pwdata[30:0];
	assign cfg_wr.phase    = pwdata;

	// whole chain moves when the output register is free or being drained
	assign adv = !out_vld_q || m_axis_tready;

	ucps_point_gen #(
		.MAX_POINTS (MAX_POINTS),
		.PHASE_BITS (PHASE_BITS)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_mode  (s_axis_tuser),
		.req_count (s_axis_tdata[6:0]),
		.cfg_wr    (cfg_wr),
		.issue     (chain[0])
	);

	// rotation chain, one cell per micro-rotation
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		ucps_cordic_cell #(
			.STAGE (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	assign tail  = chain[CORDIC_STAGES];
	// undo the half-turn fold
	assign x_fin = tail.flip ? -tail.x : tail.x;
	assign y_fin = tail.flip ? -tail.y : tail.y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.vld) begin
			out_x_q     <= to_q14(x_fin);
			out_y_q     <= to_q14(y_fin);
			out_phase_q <= tail.phase;
			out_last_q  <= tail.last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_phase_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

	`UCPS_ASSERT_NOW(a_x_range, clk, arst_n, m_axis_tvalid,
		out_x_q <= 16'sd16384 && out_x_q >= -16'sd16384, "coord_x outside unit range")
	`UCPS_ASSERT_NOW(a_y_range, clk, arst_n, m_axis_tvalid,
		out_y_q <= 16'sd16384 && out_y_q >= -16'sd16384, "coord_y outside unit range")

endmodule

`default_nettype wire
